[src/pca_pkg.sv]
`default_nettype none

package pca_pkg;

	// Depth of the disparity range and the widths that follow from it.
	localparam int DISPARITY_COUNT = 64;
	localparam int DISP_W          = (DISPARITY_COUNT > 2) ? $clog2(DISPARITY_COUNT) : 1;

	// Field widths of the channels.
	localparam int MATCH_W     = 8;
	localparam int INTENSITY_W = 8;
	localparam int COST_W      = 10;
	localparam int DISP_IDX_W  = 6;
	localparam int PEN_W       = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;

	// Width of the sums formed before saturation (up to 255 + 1023 + 255).
	localparam int SUM_W     = 12;
	localparam int DIV_CNT_W = $clog2(PEN_W);

	localparam logic [COST_W-1:0] COST_MAX = '1;

	// Register values after reset.
	localparam logic [PEN_W-1:0] PENALTY_SMALL_RESET = 8'd15;
	localparam logic [PEN_W-1:0] PENALTY_LARGE_RESET = 8'd100;
	localparam logic             DIVIDE_ENABLE_RESET = 1'b1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PENALTY_SMALL = 2'd0,
		REG_PENALTY_LARGE = 2'd1,
		REG_DIVIDE_ENABLE = 2'd2
	} cfg_reg_t;

	typedef logic [DISP_W-1:0] disp_t;
	typedef logic [COST_W-1:0] cost_t;
	typedef logic [PEN_W-1:0]  pen_t;

	// Request to and response from the penalty divider.
	typedef struct packed {
		logic start;
		pen_t dividend;
		pen_t divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		pen_t quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

[src/pca_ifs.sv]
`default_nettype none

// Matching cost beats, one disparity of one pixel per beat.
interface pca_cost_if import pca_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [MATCH_W-1:0]     match_cost;
	logic [INTENSITY_W-1:0] intensity;
	logic                   row_start;

	modport source (output valid, match_cost, intensity, row_start, input ready);
	modport sink   (input valid, match_cost, intensity, row_start, output ready);
endinterface

// Aggregated cost beats.
interface pca_result_if import pca_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [COST_W-1:0]     aggregated_cost;
	logic [DISP_IDX_W-1:0] disparity_index;
	logic                  pixel_last;

	modport source (output valid, aggregated_cost, disparity_index, pixel_last, input ready);
	modport sink   (input valid, aggregated_cost, disparity_index, pixel_last, output ready);
endinterface

// Register write channel.
interface pca_cfg_if import pca_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/pca_ram.sv]
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module pca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 2 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 2 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[src/pca_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle. The quotient is valid from
// the done pulse until the next start.
module pca_div import pca_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	pen_t                 rem_q;
	pen_t                 quo_q;
	pen_t                 divisor_q;

	logic [PEN_W:0] trial;
	logic [PEN_W:0] trial_diff;
	logic           trial_ge;

	// Shift the next dividend bit into the remainder and try the subtraction.
	always_comb begin
		trial      = {rem_q, quo_q[PEN_W-1]};
		trial_diff = trial - {1'b0, divisor_q};
		trial_ge   = (trial >= {1'b0, divisor_q});
	end

	// Step counter and handshake flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(PEN_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder and quotient; the quotient fills in as the dividend shifts out.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quo_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= trial_ge ? trial_diff[PEN_W-1:0] : trial[PEN_W-1:0];
			quo_q <= {quo_q[PEN_W-2:0], trial_ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

[src/sgm_path_cost_aggregation.sv]
// Left-to-right path cost aggregation. Costs arrive one beat per disparity,
// disparities 0 to DISPARITY_COUNT-1 of a pixel in order, pixels in row order;
// each beat yields one aggregated cost beat. The previous pixel's vector lives
// in a single RAM that is read one entry ahead and overwritten in place. For
// an ordinary beat the accept cycle issues the RAM read of entry d+1 (none
// for the last disparity), then the result cycle forms the result. At
// disparity 0 the accept cycle and a fetch cycle read entries 0 and 1, the
// large penalty is divided by the intensity change in a bit-serial divider
// (8 steps and a done pulse), then come the penalty select and the result
// cycle. The result cycle waits while the output register holds an
// unaccepted beat. A finished result waits in the output register while
// the next beat is taken. The first pixel after reset and the first pixel of
// every row pass their costs through. Registers may be written whenever no
// beat is in flight; the small penalty applies at once, the large penalty and
// the divide enable at the next disparity 0.

`default_nettype none

module sgm_path_cost_aggregation import pca_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	pca_cost_if.sink    cost_in,
	pca_result_if.source result_out,
	pca_cfg_if.sink     cfg
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_FETCH = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_PEN   = 5'b01000,
		ST_CALC  = 5'b10000
	} state_t;

	state_t state_q;

	// Configuration registers.
	pen_t p1_q;
	pen_t p2_q;
	logic div_en_q;

	// Per-pixel and per-vector state.
	disp_t                  cnt_q;
	logic                   first_q;
	cost_t                  pmin_q;
	cost_t                  curmin_q;
	logic [INTENSITY_W-1:0] prev_int_q;
	pen_t                   eff_q;
	pen_t                   change_q;

	// Beat being worked on and the old neighbours.
	logic [MATCH_W-1:0] cost_q;
	cost_t              w0_q;
	cost_t              w1_q;

	// Output register.
	logic                  out_valid_q;
	cost_t                 out_cost_q;
	logic [DISP_IDX_W-1:0] out_idx_q;
	logic                  out_last_q;

	logic in_acc;
	logic last_d;
	logic calc_fire;

	logic                   ram_re;
	disp_t                  ram_raddr;
	cost_t                  ram_rdata;
	logic [INTENSITY_W-1:0] change;

	div_req_t div_req;
	div_rsp_t div_rsp;
	pen_t     pen_sel;

	logic [SUM_W-1:0] base_x;
	logic [SUM_W-1:0] left_x;
	logic [SUM_W-1:0] right_x;
	logic [SUM_W-1:0] best_x;
	logic [SUM_W-1:0] total_x;
	logic [SUM_W-1:0] diff_x;
	cost_t            result;
	cost_t            min_next;

	assign cost_in.ready = (state_q == ST_IDLE);
	assign in_acc        = cost_in.valid && cost_in.ready;
	assign last_d        = (cnt_q == DISP_W'(DISPARITY_COUNT - 1));
	assign calc_fire     = (state_q == ST_CALC) && (!out_valid_q || result_out.ready);
	assign cfg.ready     = 1'b1;

	// Register writes; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_q     <= PENALTY_SMALL_RESET;
			p2_q     <= PENALTY_LARGE_RESET;
			div_en_q <= DIVIDE_ENABLE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_PENALTY_SMALL: p1_q     <= cfg.data;
				REG_PENALTY_LARGE: p2_q     <= cfg.data;
				REG_DIVIDE_ENABLE: div_en_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Absolute intensity change against the previous pixel.
	assign change = (cost_in.intensity > prev_int_q) ? cost_in.intensity - prev_int_q
	                                                 : prev_int_q - cost_in.intensity;

	// RAM read: entry 0 on accepting disparity 0, entry 1 in the fetch cycle,
	// otherwise entry d+1. Each entry is read before it is overwritten.
	always_comb begin
		ram_re    = (in_acc && !last_d) || (state_q == ST_FETCH);
		ram_raddr = cnt_q + DISP_W'(1);
		if (state_q == ST_FETCH) begin
			ram_raddr = DISP_W'(1);
		end else if (cnt_q == '0) begin
			ram_raddr = '0;
		end
	end

	pca_ram #(
		.WIDTH (COST_W),
		.DEPTH (DISPARITY_COUNT)
	) u_path_ram (
		.clk   (clk),
		.we    (calc_fire),
		.waddr (cnt_q),
		.wdata (result),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Divide the large penalty by the intensity change once per pixel.
	always_comb begin
		div_req.start    = (state_q == ST_FETCH);
		div_req.dividend = p2_q;
		div_req.divisor  = change_q;
	end

	pca_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Effective large penalty: no less than the small one when dividing.
	always_comb begin
		pen_sel = (change_q == '0) ? p2_q : div_rsp.quotient;
		if (pen_sel < p1_q) begin
			pen_sel = p1_q;
		end
		if (!div_en_q) begin
			pen_sel = p2_q;
		end
	end

	// Smallest of the four path candidates, then the cost update.
	always_comb begin
		base_x  = SUM_W'(pmin_q) + SUM_W'(eff_q);
		left_x  = SUM_W'(w0_q) + SUM_W'(p1_q);
		right_x = SUM_W'(ram_rdata) + SUM_W'(p1_q);
		best_x  = SUM_W'(w1_q);
		if (base_x < best_x) begin
			best_x = base_x;
		end
		if ((cnt_q != '0) && (left_x < best_x)) begin
			best_x = left_x;
		end
		if (!last_d && (right_x < best_x)) begin
			best_x = right_x;
		end
		total_x = SUM_W'(cost_q) + best_x;
		diff_x  = (total_x >= SUM_W'(pmin_q)) ? total_x - SUM_W'(pmin_q) : '0;
		if (first_q) begin
			result = COST_W'(cost_q);
		end else if (diff_x > SUM_W'(COST_MAX)) begin
			result = COST_MAX;
		end else begin
			result = diff_x[COST_W-1:0];
		end
		min_next = (result < curmin_q) ? result : curmin_q;
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= (cnt_q == '0) ? ST_FETCH : ST_CALC;
					end
				end
				ST_FETCH: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_PEN;
					end
				end
				ST_PEN: state_q <= ST_CALC;
				ST_CALC: begin
					if (calc_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Pixel and vector state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			first_q    <= 1'b1;
			pmin_q     <= '0;
			curmin_q   <= COST_MAX;
			prev_int_q <= '0;
			eff_q      <= '0;
			change_q   <= '0;
			w0_q       <= '0;
			w1_q       <= '0;
		end else begin
			if (in_acc && (cnt_q == '0)) begin
				first_q    <= first_q | cost_in.row_start;
				prev_int_q <= cost_in.intensity;
				change_q   <= change;
			end
			if (state_q == ST_FETCH) begin
				w0_q <= '0;
				w1_q <= ram_rdata;
			end
			if (state_q == ST_PEN) begin
				eff_q <= pen_sel;
			end
			if (calc_fire) begin
				w0_q <= w1_q;
				w1_q <= ram_rdata;
				if (last_d) begin
					pmin_q   <= min_next;
					curmin_q <= COST_MAX;
					first_q  <= 1'b0;
					cnt_q    <= '0;
				end else begin
					curmin_q <= min_next;
					cnt_q    <= cnt_q + DISP_W'(1);
				end
			end
		end
	end

	// Cost of the accepted beat.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cost_q <= cost_in.match_cost;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (calc_fire) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (calc_fire) begin
			out_cost_q <= result;
			out_idx_q  <= DISP_IDX_W'(cnt_q);
			out_last_q <= last_d;
		end
	end

	assign result_out.valid           = out_valid_q;
	assign result_out.aggregated_cost = out_cost_q;
	assign result_out.disparity_index = out_idx_q;
	assign result_out.pixel_last      = out_last_q;

	// A beat at disparity 0 always goes through the neighbour fetch.
	a_first_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (cnt_q == '0)) |=> (state_q == ST_FETCH))
		else $error("disparity 0 did not start the neighbour fetch");

	// The divider only answers while the sequencer waits for it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	// Closing a pixel restarts the vector and ends the pass-through.
	a_pixel_close: assert property (@(posedge clk) disable iff (!arst_n)
		(calc_fire && last_d) |=> ((cnt_q == '0) && (curmin_q == COST_MAX) && !first_q))
		else $error("pixel end did not restart the vector state");

	// The result written to the RAM is the one loaded for output.
	a_out_match: assert property (@(posedge clk) disable iff (!arst_n)
		calc_fire |=> (result_out.valid && (result_out.aggregated_cost == $past(result))))
		else $error("output register does not hold the written result");

endmodule

`default_nettype wire
